// ----- rtl/hdfv_pkg.sv -----
`default_nettype none

package hdfv_pkg;

  localparam logic [7:0] HASH_CHAR = 8'h23;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;

  localparam logic [1:0] TYPE_ADDR    = 2'd0;
  localparam logic [1:0] TYPE_PAYLOAD = 2'd1;
  localparam logic [1:0] TYPE_OTHER   = 2'd2;

  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic REG_NETWORK_ADDRESS = 1'b0;
  localparam logic REG_EXPECTED_SOURCE = 1'b1;

  localparam logic [2:0] FLD_BLOCK  = 3'd1;
  localparam logic [2:0] FLD_TYPE   = 3'd2;
  localparam logic [2:0] FLD_NET    = 3'd3;
  localparam logic [2:0] FLD_TARGET = 3'd4;
  localparam logic [2:0] FLD_SOURCE = 3'd5;
  localparam logic [2:0] FLD_MAX    = 3'd7;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  field_index;
    logic        first_byte_seen;
    logic        starts_with_hash;
    logic [31:0] number_accum;
    logic        field_canonical;
    logic        field_nonempty;
    logic        digits_done;
    logic [1:0]  type_code;
    logic        net_match;
    logic        source_match;
    logic [15:0] frame_block;
    logic [15:0] frame_target;
    logic        payload_open;
  } frame_state_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  command_byte;
    logic        frame_ok;
    logic [1:0]  frame_type;
    logic [15:0] target_device;
    logic [15:0] block_number;
    logic        run_last;
  } result_t;

  localparam frame_state_t FRAME_RESET = '{
    field_index:      3'd0,
    first_byte_seen:  1'b0,
    starts_with_hash: 1'b0,
    number_accum:     32'd0,
    field_canonical:  1'b0,
    field_nonempty:   1'b0,
    digits_done:      1'b0,
    type_code:        TYPE_OTHER,
    net_match:        1'b0,
    source_match:     1'b0,
    frame_block:      16'd0,
    frame_target:     16'd0,
    payload_open:     1'b0
  };

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (|v[31:16]) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic frame_state_t open_field(input frame_state_t s);
    frame_state_t r;
    r = s;
    r.number_accum    = 32'd0;
    r.field_canonical = 1'b0;
    r.field_nonempty  = 1'b0;
    r.digits_done     = 1'b0;
    open_field = r;
  endfunction

  function automatic frame_state_t close_field(input frame_state_t s,
                                               input logic [15:0] saved_blk,
                                               input logic [31:0] net_addr,
                                               input logic [15:0] exp_src);
    frame_state_t r;
    r = s;
    case (s.field_index)
      FLD_BLOCK: begin
        r.frame_block = sat16(s.number_accum);
      end
      FLD_TYPE: begin
        r.payload_open = s.starts_with_hash && (s.type_code == TYPE_PAYLOAD) &&
                         ({1'b0, s.frame_block} == ({1'b0, saved_blk} + 17'd1));
      end
      FLD_NET: begin
        r.net_match    = s.field_canonical && (s.number_accum == net_addr);
        r.payload_open = 1'b0;
      end
      FLD_TARGET: begin
        r.frame_target = sat16(s.number_accum);
      end
      FLD_SOURCE: begin
        r.source_match = s.field_canonical && (s.number_accum == {16'd0, exp_src});
      end
      default: begin
      end
    endcase
    close_field = r;
  endfunction

  function automatic frame_state_t take_char(input frame_state_t s,
                                             input logic [7:0] b);
    frame_state_t r;
    logic [35:0]  nv;
    r  = s;
    nv = {1'b0, s.number_accum, 3'b000} + {3'b000, s.number_accum, 1'b0}
         + {28'd0, b - CHAR_0};
    if (s.field_index == FLD_TYPE) begin
      if (!s.field_nonempty) begin
        r.type_code = (b == CHAR_A) ? TYPE_ADDR : (b == CHAR_P) ? TYPE_PAYLOAD : TYPE_OTHER;
      end else begin
        r.type_code = TYPE_OTHER;
      end
    end
    if (b >= CHAR_0 && b <= CHAR_9) begin
      if (!s.digits_done) begin
        if (!s.field_nonempty) begin
          r.field_canonical = 1'b1;
        end else if (s.number_accum == 32'd0) begin
          r.field_canonical = 1'b0;
        end
        if (|nv[35:32]) begin
          r.number_accum    = 32'hFFFF_FFFF;
          r.field_canonical = 1'b0;
        end else begin
          r.number_accum = nv[31:0];
        end
      end
    end else begin
      r.digits_done     = 1'b1;
      r.field_canonical = 1'b0;
    end
    r.field_nonempty = 1'b1;
    take_char = r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hash_delimited_frame_validator.sv -----
// Channel | Direction | Handshake         | Contents
// in_     | in        | in_tvalid/tready  | tdata received byte, tlast end of frame
// out_    | out       | out_tvalid/tready | tdata result fields, tuser kind, tlast run end
// cfg_    | in        | cfg_valid/ready   | cfg_index register, cfg_data value
//
// Each byte is parsed in the cycle it is accepted, one byte per clock while
// in_tready is high, and its zero, one or two result words are written into
// a four-word output queue. A byte is taken while the queue has room for two
// words; a byte that gives both a command word and a verdict therefore takes
// two of them. The synchronous reset empties the queue and clears the parser
// and the saved block number, saved target and both configuration registers.
`default_nettype none

module hash_delimited_frame_validator
  import hdfv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] command_byte, [8] frame_ok,
                                       // [10:9] frame_type, [26:11] target_device,
                                       // [42:27] block_number, [47:43] zero
  output logic             out_tuser,  // [0] item_kind
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  logic [31:0]  net_addr_r;
  logic [15:0]  exp_src_r;
  frame_state_t st_r, st_a, st_b, st_nxt;
  logic [15:0]  saved_block_r, saved_block_nxt;
  logic [15:0]  saved_target_r, saved_target_nxt;

  result_t      queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic         in_accept, out_accept, is_hash, cmd_hit, verdict_ok;
  logic [1:0]   verdict_type;
  result_t      cmd_word, verdict_word, word0, word1;
  logic         push0, push1;
  logic [CNT_W-1:0] push_count;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (count_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_accept = out_tvalid && out_tready;
  assign is_hash    = (in_tdata == HASH_CHAR);

  always_comb begin
    st_a = st_r;
    if (!st_r.first_byte_seen) begin
      st_a.first_byte_seen  = 1'b1;
      st_a.starts_with_hash = is_hash;
    end
    cmd_hit = 1'b0;
    if (is_hash) begin
      st_a = close_field(st_a, saved_block_r, net_addr_r, exp_src_r);
      if (st_a.field_index < FLD_MAX) begin
        st_a.field_index = st_a.field_index + 3'd1;
      end
      st_a = open_field(st_a);
    end else begin
      st_a    = take_char(st_a, in_tdata);
      cmd_hit = st_r.payload_open && (st_r.field_index == FLD_NET);
    end

    st_b             = close_field(st_a, saved_block_r, net_addr_r, exp_src_r);
    verdict_ok       = 1'b0;
    verdict_type     = TYPE_OTHER;
    saved_block_nxt  = saved_block_r;
    saved_target_nxt = saved_target_r;
    if (st_b.starts_with_hash) begin
      verdict_type = st_b.type_code;
      case (st_b.type_code)
        TYPE_ADDR: begin
          verdict_ok = st_b.net_match && st_b.source_match;
          if (verdict_ok) begin
            saved_block_nxt  = st_b.frame_block;
            saved_target_nxt = st_b.frame_target;
          end else begin
            saved_block_nxt = 16'd0;
          end
        end
        TYPE_PAYLOAD: begin
          verdict_ok      = ({1'b0, st_b.frame_block} == ({1'b0, saved_block_r} + 17'd1));
          saved_block_nxt = 16'd0;
        end
        default: begin
          saved_block_nxt = 16'd0;
        end
      endcase
    end

    if (in_tlast) begin
      st_nxt = FRAME_RESET;
    end else begin
      st_nxt           = st_a;
      saved_block_nxt  = saved_block_r;
      saved_target_nxt = saved_target_r;
    end

    cmd_word               = '0;
    cmd_word.item_kind     = KIND_COMMAND;
    cmd_word.command_byte  = in_tdata;
    cmd_word.run_last      = !in_tlast;

    verdict_word               = '0;
    verdict_word.item_kind     = KIND_VERDICT;
    verdict_word.frame_ok      = verdict_ok;
    verdict_word.frame_type    = verdict_type;
    verdict_word.target_device = saved_target_nxt;
    verdict_word.block_number  = st_b.frame_block;
    verdict_word.run_last      = 1'b1;

    word0      = cmd_hit ? cmd_word : verdict_word;
    word1      = verdict_word;
    push0      = in_accept && (cmd_hit || in_tlast);
    push1      = in_accept && cmd_hit && in_tlast;
    push_count = CNT_W'(push0) + CNT_W'(push1);
    count_nxt  = count_r + push_count - CNT_W'(out_accept);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_addr_r     <= '0;
      exp_src_r      <= '0;
      st_r           <= FRAME_RESET;
      saved_block_r  <= '0;
      saved_target_r <= '0;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      count_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NETWORK_ADDRESS: net_addr_r <= cfg_data;
          REG_EXPECTED_SOURCE: exp_src_r  <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        st_r           <= st_nxt;
        saved_block_r  <= saved_block_nxt;
        saved_target_r <= saved_target_nxt;
      end
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_count);
      if (out_accept) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      queue_r[wr_ptr_r] <= word0;
    end
    if (push1) begin
      queue_r[wr_ptr_r + PTR_W'(1)] <= word1;
    end
  end

  always_comb begin
    out_tdata        = '0;
    out_tdata[7:0]   = queue_r[rd_ptr_r].command_byte;
    out_tdata[8]     = queue_r[rd_ptr_r].frame_ok;
    out_tdata[10:9]  = queue_r[rd_ptr_r].frame_type;
    out_tdata[26:11] = queue_r[rd_ptr_r].target_device;
    out_tdata[42:27] = queue_r[rd_ptr_r].block_number;
    out_tuser        = queue_r[rd_ptr_r].item_kind;
    out_tlast        = queue_r[rd_ptr_r].run_last;
  end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import hdfv_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eof;
    bit         hold;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = 32'd0;

  hash_delimited_frame_validator i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rx_item_t    rx_bytes_q[$];
  result_t     due_words[$];
  rx_item_t    next_byte;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  int          in_wait = 0;
  int          out_wait = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b1;
  int unsigned items_made = 0;
  int unsigned items_taken = 0;
  int unsigned frames_made = 0;
  int unsigned cmd_seen = 0;
  int unsigned verdicts_seen = 0;
  int unsigned failures = 0;
  int unsigned settings = 1;
  int unsigned idle_cycles = 0;

  logic [31:0] m_net_addr = 32'd0;
  logic [15:0] m_exp_src = 16'd0;
  logic [2:0]  m_field = 3'd0;
  logic        m_seen = 1'b0;
  logic        m_hash = 1'b0;
  logic [31:0] m_accum = 32'd0;
  logic        m_canon = 1'b0;
  logic        m_nonempty = 1'b0;
  logic        m_digits_done = 1'b0;
  logic [1:0]  m_type = TYPE_OTHER;
  logic        m_net_ok = 1'b0;
  logic        m_src_ok = 1'b0;
  logic        m_stream = 1'b0;
  logic [15:0] m_blk = 16'd0;
  logic [15:0] m_tgt = 16'd0;
  logic [15:0] m_saved_blk = 16'd0;
  logic [15:0] m_saved_tgt = 16'd0;

  function automatic logic [15:0] clip16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic new_field();
    m_accum       = 32'd0;
    m_canon       = 1'b0;
    m_nonempty    = 1'b0;
    m_digits_done = 1'b0;
  endtask

  task automatic close_current_field();
    case (m_field)
      FLD_BLOCK: begin
        m_blk = clip16(m_accum);
      end
      FLD_TYPE: begin
        m_stream = m_hash && (m_type == TYPE_PAYLOAD) &&
                   ({1'b0, m_blk} == {1'b0, m_saved_blk} + 17'd1);
      end
      FLD_NET: begin
        m_net_ok = m_canon && (m_accum == m_net_addr);
        m_stream = 1'b0;
      end
      FLD_TARGET: begin
        m_tgt = clip16(m_accum);
      end
      FLD_SOURCE: begin
        m_src_ok = m_canon && (m_accum == {16'd0, m_exp_src});
      end
      default: begin
      end
    endcase
  endtask

  task automatic parse_rx_byte(input logic [7:0] b, input logic eof);
    logic [35:0] grown;
    logic        ok;
    logic [1:0]  kind;
    if (!m_seen) begin
      m_seen = 1'b1;
      m_hash = (b == HASH_CHAR);
    end
    if (b == HASH_CHAR) begin
      close_current_field();
      if (m_field < FLD_MAX) begin
        m_field = m_field + 3'd1;
      end
      new_field();
    end else begin
      if (m_field == FLD_TYPE) begin
        if (m_nonempty) begin
          m_type = TYPE_OTHER;
        end else if (b == CHAR_A) begin
          m_type = TYPE_ADDR;
        end else if (b == CHAR_P) begin
          m_type = TYPE_PAYLOAD;
        end else begin
          m_type = TYPE_OTHER;
        end
      end
      if (b >= CHAR_0 && b <= CHAR_9) begin
        if (!m_digits_done) begin
          grown = m_accum * 36'd10 + (b - CHAR_0);
          if (!m_nonempty) begin
            m_canon = 1'b1;
          end else if (m_accum == 32'd0) begin
            m_canon = 1'b0;
          end
          if (grown > 36'h0_FFFF_FFFF) begin
            m_accum = 32'hFFFF_FFFF;
            m_canon = 1'b0;
          end else begin
            m_accum = grown[31:0];
          end
        end
      end else begin
        m_digits_done = 1'b1;
        m_canon       = 1'b0;
      end
      m_nonempty = 1'b1;
      if (m_stream && m_field == FLD_NET) begin
        due_words.push_back('{item_kind: KIND_COMMAND, command_byte: b, frame_ok: 1'b0,
                              frame_type: 2'd0, target_device: 16'd0,
                              block_number: 16'd0, run_last: !eof});
      end
    end
    if (eof) begin
      ok   = 1'b0;
      kind = TYPE_OTHER;
      close_current_field();
      if (m_hash) begin
        kind = m_type;
        if (m_type == TYPE_ADDR) begin
          ok = m_net_ok && m_src_ok;
          if (ok) begin
            m_saved_blk = m_blk;
            m_saved_tgt = m_tgt;
          end else begin
            m_saved_blk = 16'd0;
          end
        end else if (m_type == TYPE_PAYLOAD) begin
          ok = ({1'b0, m_blk} == {1'b0, m_saved_blk} + 17'd1);
          m_saved_blk = 16'd0;
        end else begin
          m_saved_blk = 16'd0;
        end
      end
      due_words.push_back('{item_kind: KIND_VERDICT, command_byte: 8'd0, frame_ok: ok,
                            frame_type: kind, target_device: m_saved_tgt,
                            block_number: m_blk, run_last: 1'b1});
      m_field  = 3'd0;
      m_seen   = 1'b0;
      m_hash   = 1'b0;
      m_type   = TYPE_OTHER;
      m_net_ok = 1'b0;
      m_src_ok = 1'b0;
      m_blk    = 16'd0;
      m_tgt    = 16'd0;
      m_stream = 1'b0;
      new_field();
    end
  endtask

  task automatic check_word();
    result_t want;
    if (due_words.size() == 0) begin
      if (failures < 10) begin
        $display("unexpected word: kind=%0d data=%h last=%0d", out_tuser, out_tdata, out_tlast);
      end
      failures++;
    end else begin
      want = due_words.pop_front();
      if (want.item_kind == KIND_VERDICT) begin
        verdicts_seen++;
      end else begin
        cmd_seen++;
      end
      if (out_tuser !== want.item_kind || out_tdata[7:0] !== want.command_byte ||
          out_tdata[8] !== want.frame_ok || out_tdata[10:9] !== want.frame_type ||
          out_tdata[26:11] !== want.target_device || out_tdata[42:27] !== want.block_number ||
          out_tlast !== want.run_last) begin
        if (failures < 10) begin
          $display("word mismatch: want kind=%0d cmd=%02h ok=%0d type=%0d tgt=%0d blk=%0d last=%0d",
                   want.item_kind, want.command_byte, want.frame_ok, want.frame_type,
                   want.target_device, want.block_number, want.run_last);
          $display("               got  kind=%0d cmd=%02h ok=%0d type=%0d tgt=%0d blk=%0d last=%0d",
                   out_tuser, out_tdata[7:0], out_tdata[8], out_tdata[10:9],
                   out_tdata[26:11], out_tdata[42:27], out_tlast);
        end
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    in_fire  <= in_tvalid && in_tready;
    out_fire <= out_tvalid && out_tready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        check_word();
      end
      if (in_tvalid && in_tready) begin
        items_taken++;
        parse_rx_byte(in_tdata, in_tlast);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NETWORK_ADDRESS) begin
          m_net_addr = cfg_data;
        end else begin
          m_exp_src = cfg_data[15:0];
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == 2000) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_wait(input bit calm);
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  always @(negedge clk) begin
    if (in_fire) begin
      if ($urandom_range(0, 39) == 0) begin
        in_calm = !in_calm;
      end
      in_wait = pick_wait(in_calm);
    end
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() != 0 &&
                   !(rx_bytes_q[0].hold && due_words.size() != 0)) begin
        next_byte = rx_bytes_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_byte.data;
        in_tlast  <= next_byte.eof;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_fire) begin
      if ($urandom_range(0, 39) == 0) begin
        out_calm = !out_calm;
      end
      out_wait = pick_wait(out_calm);
    end
    if (out_wait > 0) begin
      out_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic queue_text(input string s, input bit hold);
    for (int i = 0; i < s.len(); i++) begin
      rx_bytes_q.push_back('{data: s[i], eof: (i == s.len() - 1), hold: hold && (i == 0)});
    end
    items_made += s.len();
    frames_made++;
  endtask

  task automatic queue_noise(input int len, input bit hold);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        b = HASH_CHAR;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      rx_bytes_q.push_back('{data: b, eof: (i == len - 1), hold: hold && (i == 0)});
    end
    items_made += len;
    frames_made++;
  endtask

  function automatic string num_text(input longint unsigned v);
    string t;
    t = $sformatf("%0d", v);
    case ($urandom_range(0, 31))
      0: begin
        t = "";
      end
      1: begin
        t = {"0", t};
      end
      2: begin
        t = {t, "x"};
      end
      3: begin
        t = {" ", t};
      end
      4: begin
        t = {"+", t};
      end
      default: begin
      end
    endcase
    return t;
  endfunction

  function automatic string cmd_text(input int len);
    string t;
    t = "";
    for (int i = 0; i < len; i++) begin
      t = $sformatf("%s%c", t, 8'($urandom_range(8'h24, 8'h7E)));
    end
    return t;
  endfunction

  function automatic longint unsigned pick_number();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      2: return 65534;
      3: return $urandom_range(65536, 999999);
      4: return 64'd99999999999;
      5: return $urandom;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic add_random_frame(input longint unsigned net, input longint unsigned src,
                                  input bit hold);
    longint unsigned blk;
    longint unsigned nxt;
    string           s;
    string           odd;
    int              r;
    blk = pick_number();
    nxt = ((blk > 65535) ? 65535 : blk) + 1;
    s = {"#", num_text(blk), "#A#", num_text(($urandom_range(0, 9) == 0) ? net + 1 : net),
         "#", num_text(pick_number()), "#",
         num_text(($urandom_range(0, 9) == 0) ? src + 1 : src)};
    if ($urandom_range(0, 7) == 0) begin
      s = {s, "#", cmd_text($urandom_range(0, 4)), "#9"};
    end
    r = $urandom_range(0, 19);
    if (r < 10) begin
      queue_text(s, hold);
      if ($urandom_range(0, 9) < 7) begin
        queue_text({"#", num_text(($urandom_range(0, 7) == 0) ? pick_number() : nxt), "#P#",
                    cmd_text($urandom_range(0, 8)),
                    ($urandom_range(0, 5) == 0) ? "#1#2" : ""}, 1'b0);
      end
    end else if (r < 12) begin
      queue_text({"#", num_text(pick_number()), "#P#", cmd_text($urandom_range(0, 6))}, hold);
    end else if (r < 14) begin
      queue_text(s.substr(0, $urandom_range(1, s.len()) - 1), hold);
    end else if (r < 16) begin
      queue_noise($urandom_range(1, 14), hold);
    end else if (r == 16) begin
      queue_text({cmd_text(1), s}, hold);
    end else if (r == 17) begin
      case ($urandom_range(0, 4))
        0: begin
          odd = "";
        end
        1: begin
          odd = "AA";
        end
        2: begin
          odd = "a";
        end
        3: begin
          odd = "PA";
        end
        default: begin
          odd = cmd_text(1);
        end
      endcase
      queue_text({"#", num_text(blk), "#", odd, "#", num_text(net), "#1#", num_text(src)},
                 hold);
    end else if (r == 18) begin
      queue_text({s, "#"}, hold);
    end else begin
      queue_noise(1, hold);
    end
  endtask

  task automatic settle();
    while (!(items_taken == items_made && due_words.size() == 0)) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
    end while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] net, input logic [15:0] src);
    settle();
    write_reg(REG_NETWORK_ADDRESS, net);
    write_reg(REG_EXPECTED_SOURCE, {16'd0, src});
    settings++;
  endtask

  initial begin
    longint unsigned net;
    longint unsigned src;
    int unsigned     target;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_text("#1#A#0#7#0", 1'b0);
    queue_text("#2#P#go", 1'b0);
    queue_text("#2#P#x", 1'b0);
    queue_text("#4#A#0#3#0", 1'b0);
    queue_text("Q#9#A#0#7#0", 1'b0);
    queue_text("#5#P#ok", 1'b1);
    queue_text("#1#A#00#7#0", 1'b0);
    queue_text("#1#AA#0#7#0", 1'b0);
    queue_text("#1#A", 1'b0);
    queue_text("#", 1'b0);
    queue_text("Z", 1'b0);
    queue_text("#65535#A#0#70000#0#e#f#g#h", 1'b0);
    queue_text("#65536#P#n", 1'b0);
    queue_text("#1#A#99999999999#5#0", 1'b0);
    queue_text("#3#A#0#9#-0", 1'b0);
    queue_text("#1x#A#0#5#0#", 1'b0);
    queue_text("#2#P#", 1'b0);
    queue_text("#x1#Px#ab", 1'b0);
    queue_text(" #1#A#0#7#0", 1'b0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          net = 32'hFFFF_FFFF;
          src = 16'hFFFF;
        end
        1: begin
          net = $urandom;
          src = $urandom_range(0, 65535);
        end
        2: begin
          net = 0;
          src = 0;
        end
        default: begin
          net = $urandom_range(0, 999);
          src = $urandom_range(0, 9);
        end
      endcase
      apply_setting(32'(net), 16'(src));
      if (p == 0) begin
        queue_text("#5#A#4294967295#65535#65535", 1'b0);
        queue_text("#6#P#ok", 1'b0);
        queue_text("#5#A#4294967296#1#65535", 1'b0);
        queue_text("#5#A#4294967295#1#65536", 1'b0);
      end
      target = items_made + 420;
      add_random_frame(net, src, 1'b1);
      while (items_made < target) begin
        add_random_frame(net, src, ($urandom_range(0, 24) == 0));
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d frames under %0d register settings.",
             items_taken, frames_made, settings);
    $display("Compared %0d command words and %0d verdicts; %0d failures.",
             cmd_seen, verdicts_seen, failures);
    if (failures == 0 && due_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
